// ===== rtl/core/srtc_pkg.sv =====
// shared types, command codes and constants for the serial clock / parameter ram block
// no dependencies

package srtc_pkg;

    localparam logic [31:0] CYCLES_PER_SECOND = 32'd7833600;

    // command byte classification masks and codes
    localparam logic [7:0] CMD_EXT_MASK    = 8'h78;
    localparam logic [7:0] CMD_EXT         = 8'h38;
    localparam logic [7:0] CMD_SEC_MASK    = 8'he3;
    localparam logic [7:0] CMD_SEC_RD      = 8'h81;
    localparam logic [7:0] CMD_SEC_WR      = 8'h01;
    localparam logic [7:0] CMD_PRAM8_MASK  = 8'hf3;
    localparam logic [7:0] CMD_PRAM8_RD    = 8'ha1;
    localparam logic [7:0] CMD_PRAM8_WR    = 8'h21;
    localparam logic [7:0] CMD_PRAM16_MASK = 8'hc3;
    localparam logic [7:0] CMD_PRAM16_RD   = 8'hc1;
    localparam logic [7:0] CMD_PRAM16_WR   = 8'h41;
    localparam logic [7:0] CMD_WPROT       = 8'h35;
    localparam logic [7:0] CMD_TEST        = 8'h31;

    typedef enum logic [1:0] {
        PH_CMD      = 2'd0,
        PH_DATA     = 2'd1,
        PH_EXT2     = 2'd2,
        PH_EXT_DATA = 2'd3
    } t_phase;

    typedef struct packed {
        logic        func;
        logic [2:0]  lines;
        logic [15:0] cycles;
        logic [31:0] seconds_adjust;
    } t_in;

    typedef struct packed {
        logic data_driven;
        logic data_bit;
        logic second_pulse;
    } t_out;

    typedef struct packed {
        logic       rd;
        logic       wr;
        logic [7:0] addr;
        logic [7:0] wdata;
    } t_pram_req;

    typedef struct packed {
        logic       en;
        logic [1:0] sel;
        logic [7:0] data;
    } t_sec_wr;

    // parameter ram contents after reset
    function automatic logic [7:0] pram_default(input logic [7:0] addr);
        logic [7:0] val;
        case (addr)
            8'h08:   val = 8'h18;
            8'h09:   val = 8'h88;
            8'h0b:   val = 8'h20;
            8'h10:   val = 8'ha8;
            8'h13:   val = 8'h22;
            8'h1e:   val = 8'h64;
            default: val = 8'h00;
        endcase
        return val;
    endfunction

endpackage

// ===== rtl/core/srtc_pram.sv =====
// 256 x 8 parameter ram with registered read and per-entry valid bits
// depends on srtc_pkg (request struct, reset contents)

module srtc_pram (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  srtc_pkg::t_pram_req i_req,
    output logic [7:0]          o_rdata
);
    import srtc_pkg::*;

    logic [7:0] mem [256];
    logic [255:0] r_valid;
    logic [7:0] r_q;
    logic       r_hit;
    logic [7:0] r_def;

    always_ff @(posedge i_clk) begin
        if (i_req.wr) begin
            mem[i_req.addr] <= i_req.wdata;
        end
        if (i_req.rd) begin
            r_q   <= mem[i_req.addr];
            r_def <= pram_default(i_req.addr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_hit   <= 1'b0;
        end else begin
            if (i_req.wr) begin
                r_valid[i_req.addr] <= 1'b1;
            end
            if (i_req.rd) begin
                r_hit <= r_valid[i_req.addr];
            end
        end
    end

    // an entry never written reads as its reset contents
    assign o_rdata = r_hit ? r_q : r_def;

endmodule

// ===== rtl/core/srtc_timer.sv =====
// seconds counter and cycle prescaler, with byte writes from the serial side
// depends on srtc_pkg (CYCLES_PER_SECOND, t_sec_wr)

module srtc_timer (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_tick,
    input  logic [15:0]       i_cycles,
    input  logic [31:0]       i_adjust,
    input  srtc_pkg::t_sec_wr i_sec_wr,
    output logic [31:0]       o_seconds,
    output logic              o_pulse
);
    import srtc_pkg::*;

    logic [31:0] r_seconds, n_seconds;
    logic [31:0] r_cycle_cnt, n_cycle_cnt;
    logic [31:0] cyc_sum;
    logic        wrap;

    assign cyc_sum = r_cycle_cnt + {16'd0, i_cycles};
    assign wrap    = cyc_sum > CYCLES_PER_SECOND;

    always_comb begin
        n_seconds   = r_seconds;
        n_cycle_cnt = r_cycle_cnt;
        if (i_tick) begin
            n_cycle_cnt = wrap ? cyc_sum - CYCLES_PER_SECOND : cyc_sum;
            n_seconds   = r_seconds + i_adjust + {31'd0, wrap};
        end else if (i_sec_wr.en) begin
            case (i_sec_wr.sel)
                2'd0:    n_seconds[7:0]   = i_sec_wr.data;
                2'd1:    n_seconds[15:8]  = i_sec_wr.data;
                2'd2:    n_seconds[23:16] = i_sec_wr.data;
                default: n_seconds[31:24] = i_sec_wr.data;
            endcase
        end
    end

    // seconds change unless adjust plus wrap is zero mod 2^32
    assign o_pulse = i_tick && (wrap ? (i_adjust != 32'hffff_ffff) : (i_adjust != 32'd0));
    assign o_seconds = r_seconds;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seconds   <= '0;
            r_cycle_cnt <= '0;
        end else begin
            r_seconds   <= n_seconds;
            r_cycle_cnt <= n_cycle_cnt;
        end
    end

endmodule

// ===== rtl/core/srtc_serial.sv =====
// three-wire serial protocol engine: command decode, bit shifting, write protect
// depends on srtc_pkg (command codes, t_phase, t_pram_req, t_sec_wr)

module srtc_serial (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_line_en,
    input  logic [2:0]          i_lines,
    input  logic [31:0]         i_seconds,
    input  logic [7:0]          i_ram_rdata,
    output srtc_pkg::t_pram_req o_ram_req,
    output srtc_pkg::t_sec_wr   o_sec_wr,
    output logic                o_driven,
    output logic                o_data_level
);
    import srtc_pkg::*;

    t_phase     r_phase, n_phase;
    logic [2:0] r_last, n_last;
    logic [7:0] r_shift, n_shift;
    logic [7:0] r_first, n_first;
    logic [7:0] r_second, n_second;
    logic [2:0] r_bitcnt, n_bitcnt;
    logic       r_sending, n_sending;
    logic       r_level, n_level;
    logic       r_wp, n_wp;
    logic       r_ld_pend, n_ld_pend;

    logic [7:0] eff_shift;
    logic [7:0] sh_in;
    logic       shift_go;
    logic       byte_done;
    logic       first_ext;

    // ram read data enters the shift register in the cycle after the request
    assign eff_shift = r_ld_pend ? i_ram_rdata : r_shift;
    assign sh_in     = {eff_shift[6:0], i_lines[0]};
    assign shift_go  = i_line_en && !i_lines[2] && r_last[1] && !i_lines[1];
    assign byte_done = shift_go && !r_sending && (r_bitcnt == 3'd7);
    assign first_ext = (sh_in & CMD_EXT_MASK) == CMD_EXT;

    always_comb begin
        n_phase   = r_phase;
        n_sending = r_sending;
        n_bitcnt  = r_bitcnt;
        if (i_line_en && i_lines[2]) begin
            n_phase   = PH_CMD;
            n_sending = 1'b0;
            n_bitcnt  = '0;
        end else if (shift_go) begin
            n_bitcnt = r_bitcnt + 3'd1;
            if (r_sending) begin
                if (r_bitcnt == 3'd7) begin
                    n_sending = 1'b0;
                    n_phase   = PH_CMD;
                end
            end else if (byte_done) begin
                unique case (r_phase)
                    PH_CMD: begin
                        if (first_ext) begin
                            n_phase = PH_EXT2;
                        end else if (sh_in[7]) begin
                            n_phase   = PH_CMD;
                            n_sending = 1'b1;
                        end else begin
                            n_phase = PH_DATA;
                        end
                    end
                    PH_DATA: n_phase = PH_CMD;
                    PH_EXT2: begin
                        if (r_first[7]) begin
                            n_phase   = PH_CMD;
                            n_sending = 1'b1;
                        end else begin
                            n_phase = PH_EXT_DATA;
                        end
                    end
                    PH_EXT_DATA: n_phase = PH_CMD;
                    default: n_phase = PH_CMD;
                endcase
            end
        end
    end

    always_comb begin
        n_last    = i_line_en ? i_lines : r_last;
        n_shift   = eff_shift;
        n_ld_pend = 1'b0;
        n_first   = r_first;
        n_second  = r_second;
        n_level   = r_level;
        n_wp      = r_wp;
        o_driven  = 1'b0;
        o_ram_req = '0;
        o_sec_wr  = '0;
        if (shift_go) begin
            if (r_sending) begin
                n_level  = eff_shift[7];
                n_shift  = {eff_shift[6:0], eff_shift[7]};
                o_driven = 1'b1;
            end else begin
                n_shift = sh_in;
                if (byte_done) begin
                    unique case (r_phase)
                        PH_CMD: begin
                            n_first = sh_in;
                            if (!first_ext && sh_in[7]) begin
                                if ((sh_in & CMD_SEC_MASK) == CMD_SEC_RD) begin
                                    case (sh_in[3:2])
                                        2'd0:    n_shift = i_seconds[7:0];
                                        2'd1:    n_shift = i_seconds[15:8];
                                        2'd2:    n_shift = i_seconds[23:16];
                                        default: n_shift = i_seconds[31:24];
                                    endcase
                                end else if ((sh_in & CMD_PRAM8_MASK) == CMD_PRAM8_RD) begin
                                    o_ram_req.rd   = 1'b1;
                                    o_ram_req.addr = {6'b000010, sh_in[3:2]};
                                    n_ld_pend      = 1'b1;
                                end else if ((sh_in & CMD_PRAM16_MASK) == CMD_PRAM16_RD) begin
                                    o_ram_req.rd   = 1'b1;
                                    o_ram_req.addr = {4'b0001, sh_in[5:2]};
                                    n_ld_pend      = 1'b1;
                                end else begin
                                    n_shift = 8'h00;
                                end
                            end
                        end
                        PH_DATA: begin
                            if (r_first == CMD_WPROT) begin
                                n_wp = sh_in[7];
                            end else if (!r_wp) begin
                                if ((r_first & CMD_SEC_MASK) == CMD_SEC_WR) begin
                                    o_sec_wr.en   = 1'b1;
                                    o_sec_wr.sel  = r_first[3:2];
                                    o_sec_wr.data = sh_in;
                                end else if ((r_first & CMD_PRAM8_MASK) == CMD_PRAM8_WR) begin
                                    o_ram_req.wr    = 1'b1;
                                    o_ram_req.addr  = {6'b000010, r_first[3:2]};
                                    o_ram_req.wdata = sh_in;
                                end else if (r_first == CMD_TEST) begin
                                    // test register has no visible effect
                                    o_ram_req.wr = 1'b0;
                                end else if ((r_first & CMD_PRAM16_MASK) == CMD_PRAM16_WR) begin
                                    o_ram_req.wr    = 1'b1;
                                    o_ram_req.addr  = {4'b0001, r_first[5:2]};
                                    o_ram_req.wdata = sh_in;
                                end
                            end
                        end
                        PH_EXT2: begin
                            n_second = sh_in;
                            if (r_first[7]) begin
                                o_ram_req.rd   = 1'b1;
                                o_ram_req.addr = {r_first[2:0], sh_in[6:2]};
                                n_ld_pend      = 1'b1;
                            end
                        end
                        PH_EXT_DATA: begin
                            if (!r_wp) begin
                                o_ram_req.wr    = 1'b1;
                                o_ram_req.addr  = {r_first[2:0], r_second[6:2]};
                                o_ram_req.wdata = sh_in;
                            end
                        end
                        default: n_first = r_first;
                    endcase
                end
            end
        end
    end

    assign o_data_level = n_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_CMD;
            r_last    <= '0;
            r_shift   <= '0;
            r_first   <= '0;
            r_second  <= '0;
            r_bitcnt  <= '0;
            r_sending <= 1'b0;
            r_level   <= 1'b0;
            r_wp      <= 1'b0;
            r_ld_pend <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_last    <= n_last;
            r_shift   <= n_shift;
            r_first   <= n_first;
            r_second  <= n_second;
            r_bitcnt  <= n_bitcnt;
            r_sending <= n_sending;
            r_level   <= n_level;
            r_wp      <= n_wp;
            r_ld_pend <= n_ld_pend;
        end
    end

endmodule

// ===== rtl/core/serial_rtc_pram_chip.sv =====
// top level of the serial real-time clock with parameter ram
// depends on srtc_pkg, srtc_pram, srtc_timer, srtc_serial
//
//   channel | valid       | ready       | payload
//   --------+-------------+-------------+---------------------
//   input   | i_in_valid  | o_in_ready  | i_in_data  (t_in)
//   result  | o_out_valid | i_out_ready | o_out_data (t_out)
//
// an item is captured in the input register at its transfer and is processed once the output
// register is free or being emptied; its result is then registered in the output register
// one item per cycle sustained while the receiver is ready; the input register keeps taking
// items while a result waits, until both registers are full
// synchronous active-low reset; parameter ram entries read as their defaults
// until written, through one valid bit per entry, so no clearing pass

module serial_rtc_pram_chip (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  srtc_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output srtc_pkg::t_out o_out_data
);
    import srtc_pkg::*;

    logic      r_in_v;
    t_in       r_in;
    logic      r_out_v;
    t_out      r_out;
    logic      fire;

    t_pram_req ram_req;
    t_sec_wr   sec_wr;
    logic [7:0]  ram_rdata;
    logic [31:0] seconds;
    logic      driven;
    logic      level;
    logic      pulse;

    assign fire       = r_in_v && (!r_out_v || i_out_ready);
    assign o_in_ready = !r_in_v || fire;

    srtc_pram u_pram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (ram_req),
        .o_rdata (ram_rdata)
    );

    srtc_timer u_timer (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_tick    (fire && r_in.func),
        .i_cycles  (r_in.cycles),
        .i_adjust  (r_in.seconds_adjust),
        .i_sec_wr  (sec_wr),
        .o_seconds (seconds),
        .o_pulse   (pulse)
    );

    srtc_serial u_serial (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_line_en    (fire && !r_in.func),
        .i_lines      (r_in.lines),
        .i_seconds    (seconds),
        .i_ram_rdata  (ram_rdata),
        .o_ram_req    (ram_req),
        .o_sec_wr     (sec_wr),
        .o_driven     (driven),
        .o_data_level (level)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_v <= i_in_valid;
            end
            if (fire) begin
                r_out_v <= 1'b1;
            end else if (i_out_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (fire) begin
            r_out.data_driven  <= driven;
            r_out.data_bit     <= level;
            r_out.second_pulse <= pulse;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

endmodule

// ===== sim/tb_serial_rtc_pram_chip.sv =====
// testbench for serial_rtc_pram_chip: drives serial line and tick transfers and predicts
// every result with a behavioral copy of the clock chip state
// depends on srtc_pkg and the rtl under rtl/core
module tb_serial_rtc_pram_chip;
    timeunit 1ns;
    timeprecision 1ps;

    import srtc_pkg::*;

    localparam int         HOLD_CYCLES  = 80;
    localparam int         STALL_LIMIT  = 1000;
    localparam int         DRAIN_CYCLES = 8;
    localparam logic [7:0] RD_FLAG      = 8'h80;

    typedef enum int {
        TX_SEC_RD, TX_SEC_WR, TX_PRAM8_RD, TX_PRAM8_WR, TX_PRAM16_RD, TX_PRAM16_WR,
        TX_WPROT_WR, TX_TEST_WR, TX_EXT_RD, TX_EXT_WR, TX_RAW_CMD, TX_ABORT
    } t_txn;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    t_in  i_in_data = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_out o_out_data;

    int snd_idle_pct = 0;
    int rcv_idle_pct = 0;
    int items_sent = 0;
    int mismatch_cnt = 0;
    int stall_cnt = 0;
    bit hold_req = 1'b0;

    t_out response_q[$];

    // predicted chip state
    logic [2:0]  pv_lines;
    logic [7:0]  pv_shift;
    logic [7:0]  pv_cmd1;
    logic [7:0]  pv_cmd2;
    t_phase      pv_phase;
    logic [3:0]  pv_bits;
    logic        pv_sending;
    logic        pv_level;
    logic [7:0]  pv_pram [256];
    logic [31:0] pv_seconds;
    logic [31:0] pv_cycles;
    logic        pv_wprot;
    logic [7:0]  pv_test;

    serial_rtc_pram_chip dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic void rtc_reset();
        pv_lines = '0;
        pv_shift = '0;
        pv_cmd1 = '0;
        pv_cmd2 = '0;
        pv_phase = PH_CMD;
        pv_bits = '0;
        pv_sending = 1'b0;
        pv_level = 1'b0;
        pv_seconds = '0;
        pv_cycles = '0;
        pv_wprot = 1'b0;
        pv_test = '0;
        foreach (pv_pram[k]) pv_pram[k] = '0;
        pv_pram[8'h08] = 8'h18;
        pv_pram[8'h09] = 8'h88;
        pv_pram[8'h0b] = 8'h20;
        pv_pram[8'h10] = 8'ha8;
        pv_pram[8'h13] = 8'h22;
        pv_pram[8'h1e] = 8'h64;
    endfunction

    function automatic logic [7:0] rtc_short_read(input logic [7:0] c);
        logic [1:0] sel;
        sel = c[3:2];
        if ((c & CMD_SEC_MASK) == CMD_SEC_RD)
            return pv_seconds[{sel, 3'b000} +: 8];
        else if ((c & CMD_PRAM8_MASK) == CMD_PRAM8_RD)
            return pv_pram[8'd8 + 8'(sel)];
        else if ((c & CMD_PRAM16_MASK) == CMD_PRAM16_RD)
            return pv_pram[8'd16 + 8'(c[5:2])];
        return '0;
    endfunction

    function automatic void rtc_short_write(input logic [7:0] c, input logic [7:0] d);
        logic [1:0] sel;
        sel = c[3:2];
        if (c == CMD_WPROT) begin
            pv_wprot = d[7];
            return;
        end
        if (pv_wprot)
            return;
        if ((c & CMD_SEC_MASK) == CMD_SEC_WR)
            pv_seconds[{sel, 3'b000} +: 8] = d;
        else if ((c & CMD_PRAM8_MASK) == CMD_PRAM8_WR)
            pv_pram[8'd8 + 8'(sel)] = d;
        else if (c == CMD_TEST)
            pv_test = d;
        else if ((c & CMD_PRAM16_MASK) == CMD_PRAM16_WR)
            pv_pram[8'd16 + 8'(c[5:2])] = d;
    endfunction

    // returns 1 when a read bit went out on this update
    function automatic logic rtc_lines(input logic [2:0] v);
        logic [2:0] dif;
        logic [7:0] ext_addr;
        dif = pv_lines ^ v;
        pv_lines = v;
        if (v[2]) begin
            pv_phase = PH_CMD;
            pv_sending = 1'b0;
            pv_bits = '0;
            return 1'b0;
        end
        if (!(dif[1] && !v[1]))
            return 1'b0;
        if (pv_sending) begin
            pv_level = pv_shift[7];
            pv_shift = {pv_shift[6:0], pv_shift[7]};
            pv_bits++;
            if (pv_bits >= 4'd8) begin
                pv_bits = '0;
                pv_sending = 1'b0;
                pv_phase = PH_CMD;
            end
            return 1'b1;
        end
        pv_shift = {pv_shift[6:0], v[0]};
        pv_bits++;
        if (pv_bits >= 4'd8) begin
            ext_addr = {pv_cmd1[2:0], pv_cmd2[6:2]};
            case (pv_phase)
                PH_CMD: begin
                    pv_cmd1 = pv_shift;
                    if ((pv_cmd1 & CMD_EXT_MASK) == CMD_EXT) begin
                        pv_phase = PH_EXT2;
                    end else if (pv_cmd1[7]) begin
                        pv_shift = rtc_short_read(pv_cmd1);
                        pv_phase = PH_CMD;
                        pv_sending = 1'b1;
                    end else begin
                        pv_phase = PH_DATA;
                    end
                end
                PH_DATA: begin
                    rtc_short_write(pv_cmd1, pv_shift);
                    pv_phase = PH_CMD;
                end
                PH_EXT2: begin
                    pv_cmd2 = pv_shift;
                    ext_addr = {pv_cmd1[2:0], pv_cmd2[6:2]};
                    if (pv_cmd1[7]) begin
                        pv_shift = pv_pram[ext_addr];
                        pv_phase = PH_CMD;
                        pv_sending = 1'b1;
                    end else begin
                        pv_phase = PH_EXT_DATA;
                    end
                end
                default: begin
                    if (!pv_wprot)
                        pv_pram[ext_addr] = pv_shift;
                    pv_phase = PH_CMD;
                end
            endcase
            pv_bits = '0;
        end
        return 1'b0;
    endfunction

    function automatic t_out rtc_respond(input t_in it);
        t_out        r;
        logic [31:0] old_sec;
        r = '0;
        if (it.func == 1'b0) begin
            r.data_driven = rtc_lines(it.lines);
        end else begin
            old_sec = pv_seconds;
            pv_cycles = pv_cycles + 32'(it.cycles);
            if (pv_cycles > CYCLES_PER_SECOND) begin
                pv_cycles = pv_cycles - CYCLES_PER_SECOND;
                pv_seconds = pv_seconds + 32'd1;
            end
            pv_seconds = pv_seconds + it.seconds_adjust;
            r.second_pulse = (pv_seconds != old_sec);
        end
        r.data_bit = pv_level;
        return r;
    endfunction

    task automatic send_item(input t_in it);
        if ($urandom_range(99) < snd_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= it;
        do @(posedge i_clk); while (!o_in_ready);
        response_q.push_back(rtc_respond(it));
        items_sent++;
    endtask

    task automatic drive_lines(input logic [2:0] v);
        t_in it;
        it.func = 1'b0;
        it.lines = v;
        it.cycles = 16'($urandom);
        it.seconds_adjust = $urandom;
        send_item(it);
    endtask

    task automatic drive_tick(input logic [15:0] cyc, input logic [31:0] adj);
        t_in it;
        it.func = 1'b1;
        it.lines = 3'($urandom);
        it.cycles = cyc;
        it.seconds_adjust = adj;
        send_item(it);
    endtask

    task automatic random_tick();
        logic [15:0] cyc;
        logic [31:0] adj;
        int          r;
        cyc = ($urandom_range(9) < 9) ? 16'($urandom_range(50000, 65535)) : 16'($urandom);
        r = $urandom_range(99);
        if (pv_cycles + 32'(cyc) > CYCLES_PER_SECOND && r < 75)
            adj = '1;  // wrap adds one second, all ones takes it back
        else if (r < 50)
            adj = '0;
        else if (r < 65)
            adj = '1;
        else if (r < 80)
            adj = 32'd1;
        else
            adj = $urandom;
        drive_tick(cyc, adj);
    endtask

    // msb first, one falling serial clock edge per bit; data is don't-care while reading
    task automatic clock_byte(input logic [7:0] b);
        for (int i = 7; i >= 0; i--) begin
            drive_lines({1'b0, 1'b1, b[i]});
            if ($urandom_range(9) == 0)
                drive_lines({1'b0, 1'b1, ~b[i]});
            if ($urandom_range(11) == 0)
                random_tick();
            drive_lines({1'b0, 1'b0, b[i]});
            if ($urandom_range(15) == 0)
                drive_lines({1'b0, 1'b0, 1'($urandom)});
        end
    endtask

    task automatic rtc_transaction();
        t_txn       kind;
        logic [1:0] sel;
        logic [3:0] idx;
        logic [7:0] addr;
        kind = t_txn'($urandom_range(TX_ABORT));
        sel = 2'($urandom);
        idx = 4'($urandom);
        addr = 8'($urandom);
        drive_lines({1'b1, 2'($urandom)});
        case (kind)
            TX_SEC_RD: begin
                clock_byte(CMD_SEC_RD | {4'b0, sel, 2'b00});
                clock_byte(8'($urandom));
            end
            TX_SEC_WR: begin
                clock_byte(CMD_SEC_WR | {4'b0, sel, 2'b00});
                clock_byte(8'($urandom));
            end
            TX_PRAM8_RD: begin
                clock_byte(CMD_PRAM8_RD | {4'b0, sel, 2'b00});
                clock_byte(8'($urandom));
            end
            TX_PRAM8_WR: begin
                clock_byte(CMD_PRAM8_WR | {4'b0, sel, 2'b00});
                clock_byte(8'($urandom));
            end
            TX_PRAM16_RD: begin
                clock_byte(CMD_PRAM16_RD | {2'b0, idx, 2'b00});
                clock_byte(8'($urandom));
            end
            TX_PRAM16_WR: begin
                clock_byte(CMD_PRAM16_WR | {2'b0, idx, 2'b00});
                clock_byte(8'($urandom));
            end
            TX_WPROT_WR: begin
                // mostly clear protection so that writes keep landing
                clock_byte(CMD_WPROT);
                clock_byte({$urandom_range(9) < 3, 7'($urandom)});
            end
            TX_TEST_WR: begin
                clock_byte(CMD_TEST);
                clock_byte(8'($urandom));
            end
            TX_EXT_RD: begin
                clock_byte(CMD_EXT | RD_FLAG | {5'b0, addr[7:5]});
                clock_byte({1'($urandom), addr[4:0], 2'($urandom)});
                clock_byte(8'($urandom));
            end
            TX_EXT_WR: begin
                clock_byte(CMD_EXT | {5'b0, addr[7:5]});
                clock_byte({1'($urandom), addr[4:0], 2'($urandom)});
                clock_byte(8'($urandom));
            end
            TX_RAW_CMD: begin
                repeat (3) clock_byte(8'($urandom));
            end
            default: begin
                // partial command, cut short by the next enable
                repeat ($urandom_range(1, 6)) drive_lines({1'b0, 2'($urandom)});
            end
        endcase
    endtask

    task automatic test_line_edges();
        drive_lines(3'b100);
        drive_lines(3'b111);
        drive_lines(3'b011);
        drive_lines(3'b001);
        drive_lines(3'b010);
        drive_tick(16'h0000, 32'h0000_0000);
        drive_lines(3'b000);
        drive_lines(3'b110);
        drive_lines(3'b101);
        drive_lines(3'b000);
        drive_lines(3'b011);
        drive_lines(3'b100);
        drive_lines(3'b000);
    endtask

    task automatic test_tick_extremes();
        drive_tick(16'h0000, 32'h0000_0000);
        drive_tick(16'h0000, 32'hffff_ffff);
        drive_tick(16'hffff, 32'h0000_0000);
        drive_tick(16'hffff, 32'h0000_0001);
        drive_tick(16'h8000, 32'h8000_0000);
        drive_tick(16'h7fff, 32'h7fff_ffff);
    endtask

    task automatic test_random(input int snd_pct, input int rcv_pct, input int n_items);
        int stop_at;
        int r;
        snd_idle_pct = snd_pct;
        rcv_idle_pct = rcv_pct;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            r = $urandom_range(99);
            if (r < 40)
                repeat ($urandom_range(1, 24)) random_tick();
            else if (r < 48)
                repeat ($urandom_range(1, 6)) drive_lines(3'($urandom));
            else
                rtc_transaction();
        end
    endtask

    // receiver holds off while items keep coming, so the input side backs up
    task automatic test_input_stall();
        snd_idle_pct = 0;
        hold_req = 1'b1;
        repeat (12) begin
            drive_lines(3'($urandom));
            random_tick();
        end
    endtask

    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                i_out_ready <= ($urandom_range(99) >= rcv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (response_q.size() == 0) begin
                $error("result transfer with no result pending: %b", o_out_data);
                mismatch_cnt++;
            end else begin
                want = response_q.pop_front();
                if (o_out_data.data_driven !== want.data_driven) begin
                    $error("data_driven: expected %0b, got %0b",
                           want.data_driven, o_out_data.data_driven);
                    mismatch_cnt++;
                end
                if (o_out_data.data_bit !== want.data_bit) begin
                    $error("data_bit: expected %0b, got %0b",
                           want.data_bit, o_out_data.data_bit);
                    mismatch_cnt++;
                end
                if (o_out_data.second_pulse !== want.second_pulse) begin
                    $error("second_pulse: expected %0b, got %0b",
                           want.second_pulse, o_out_data.second_pulse);
                    mismatch_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                stall_cnt <= 0;
            end else if (stall_cnt >= STALL_LIMIT) begin
                $display("FAIL");
                $finish;
            end else begin
                stall_cnt <= stall_cnt + 1;
            end
        end
    end

    initial begin
        rtc_reset();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_line_edges();
        test_tick_extremes();
        test_random(29, 53, 520);
        test_input_stall();
        test_random(53, 29, 520);
        test_random(0, 0, 520);

        i_in_valid <= 1'b0;
        while (response_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/srtc_pkg.sv
rtl/core/srtc_pram.sv
rtl/core/srtc_timer.sv
rtl/core/srtc_serial.sv
rtl/core/serial_rtc_pram_chip.sv
sim/tb_serial_rtc_pram_chip.sv
